>>> rtl/ccc_pkg.sv
package ccc_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;
  localparam int RADIUS_BITS      = COORD_BITS - 1;
  localparam int MAG_BITS         = COORD_BITS + 1;
  localparam int SQ_BITS          = 2 * MAG_BITS;
  localparam int ROOT_BITS        = MAG_BITS;
  localparam int REM_BITS         = ROOT_BITS + 1;
  localparam int QUOT_BITS        = NORMAL_FRAC_BITS + 1;
  localparam int NUM_BITS         = MAG_BITS + NORMAL_FRAC_BITS;
  localparam int DREM_BITS        = ROOT_BITS;
  localparam int PROD_BITS        = QUOT_BITS + RADIUS_BITS;

  typedef struct packed {
    logic [MAG_BITS-1:0]    mx;
    logic [MAG_BITS-1:0]    my;
    logic                   nxneg;
    logic                   nyneg;
    logic [RADIUS_BITS-1:0] ra;
    logic [RADIUS_BITS-1:0] rb;
    logic                   hit;
    logic                   coinc;
  } side_t;

  typedef struct packed {
    logic                  valid;
    logic [REM_BITS-1:0]   rem;
    logic [ROOT_BITS-1:0]  root;
    logic [SQ_BITS-1:0]    rad;
    side_t                 side;
  } sq_t;

  typedef struct packed {
    logic                  valid;
    logic [ROOT_BITS-1:0]  den;
    logic [DREM_BITS-1:0]  rem_x;
    logic [QUOT_BITS-1:0]  low_x;
    logic [QUOT_BITS-1:0]  q_x;
    logic [DREM_BITS-1:0]  rem_y;
    logic [QUOT_BITS-1:0]  low_y;
    logic [QUOT_BITS-1:0]  q_y;
    side_t                 side;
  } dv_t;

endpackage

>>> rtl/ccc_sqrt_cell.sv
module ccc_sqrt_cell (
  input  logic         clk,
  input  logic         rst,
  input  ccc_pkg::sq_t d,
  output ccc_pkg::sq_t q
);

  logic [ccc_pkg::REM_BITS+1:0] trial;
  logic [ccc_pkg::REM_BITS+1:0] sub;
  ccc_pkg::sq_t                 q_next;

  // one root digit: try to subtract (4*root + 1) from the extended remainder
  always_comb begin
    trial  = {d.rem, d.rad[ccc_pkg::SQ_BITS-1 -: 2]};
    sub    = {1'b0, d.root, 2'b01};
    q_next = d;
    q_next.rad = {d.rad[ccc_pkg::SQ_BITS-3:0], 2'b00};
    if (trial >= sub) begin
      q_next.rem  = ccc_pkg::REM_BITS'(trial - sub);
      q_next.root = {d.root[ccc_pkg::ROOT_BITS-2:0], 1'b1};
    end else begin
      q_next.rem  = ccc_pkg::REM_BITS'(trial);
      q_next.root = {d.root[ccc_pkg::ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule

>>> rtl/ccc_div_cell.sv
module ccc_div_cell (
  input  logic         clk,
  input  logic         rst,
  input  ccc_pkg::dv_t d,
  output ccc_pkg::dv_t q
);

  logic [ccc_pkg::DREM_BITS:0] trial_x;
  logic [ccc_pkg::DREM_BITS:0] trial_y;
  ccc_pkg::dv_t                q_next;

  // one quotient bit per lane, shared divisor
  always_comb begin
    trial_x = {d.rem_x, d.low_x[ccc_pkg::QUOT_BITS-1]};
    trial_y = {d.rem_y, d.low_y[ccc_pkg::QUOT_BITS-1]};
    q_next  = d;
    q_next.low_x = {d.low_x[ccc_pkg::QUOT_BITS-2:0], 1'b0};
    q_next.low_y = {d.low_y[ccc_pkg::QUOT_BITS-2:0], 1'b0};
    if (trial_x >= {1'b0, d.den}) begin
      q_next.rem_x = ccc_pkg::DREM_BITS'(trial_x - {1'b0, d.den});
      q_next.q_x   = {d.q_x[ccc_pkg::QUOT_BITS-2:0], 1'b1};
    end else begin
      q_next.rem_x = ccc_pkg::DREM_BITS'(trial_x);
      q_next.q_x   = {d.q_x[ccc_pkg::QUOT_BITS-2:0], 1'b0};
    end
    if (trial_y >= {1'b0, d.den}) begin
      q_next.rem_y = ccc_pkg::DREM_BITS'(trial_y - {1'b0, d.den});
      q_next.q_y   = {d.q_y[ccc_pkg::QUOT_BITS-2:0], 1'b1};
    end else begin
      q_next.rem_y = ccc_pkg::DREM_BITS'(trial_y);
      q_next.q_y   = {d.q_y[ccc_pkg::QUOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule

>>> rtl/circle_circle_contact.sv
// Circle against circle contact test, fully pipelined.
//
// Input channel: drive both circles (centre and radius, Q16.8) and raise
// start. An item is taken at every rising edge where start is high and
// busy is low; busy is always low, so a new item may enter every cycle.
//
// Result channel: done flags each result, with hit, normal, arms and
// coincident valid alongside. Results leave in the order items came in.
// Throughput is one item per cycle: the square root runs as a row of 25
// cells (one root bit each) and the normal division as a row of 15 cells
// (one quotient bit each, both axes in parallel); every cell hands its
// partial result on at every edge.
//
// The receiver cannot stall, so no result is ever held back or dropped.
// Synchronous reset empties the pipeline: no done pulse follows reset
// until a new item has been taken.
module circle_circle_contact (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]    a_pos_x,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]    a_pos_y,
  input  logic        [ccc_pkg::RADIUS_BITS-1:0]   a_radius,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]    b_pos_x,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]    b_pos_y,
  input  logic        [ccc_pkg::RADIUS_BITS-1:0]   b_radius,
  output logic                                     done,
  output logic                                     hit,
  output logic signed [ccc_pkg::NORMAL_BITS-1:0]   normal_x,
  output logic signed [ccc_pkg::NORMAL_BITS-1:0]   normal_y,
  output logic signed [ccc_pkg::COORD_BITS-1:0]    arm_a_x,
  output logic signed [ccc_pkg::COORD_BITS-1:0]    arm_a_y,
  output logic signed [ccc_pkg::COORD_BITS-1:0]    arm_b_x,
  output logic signed [ccc_pkg::COORD_BITS-1:0]    arm_b_y,
  output logic                                     coincident
);

  localparam int SQ_CELLS  = ccc_pkg::ROOT_BITS;
  localparam int DIV_CELLS = ccc_pkg::QUOT_BITS;
  localparam int MB        = ccc_pkg::MAG_BITS;
  localparam int RB        = ccc_pkg::RADIUS_BITS;
  localparam int NF        = ccc_pkg::NORMAL_FRAC_BITS;

  assign busy = 1'b0;

  // stage 1: centre offset, split into sign and magnitude
  logic                          s1_valid;
  logic [MB-1:0]                 s1_mx, s1_my;
  logic                          s1_nxneg, s1_nyneg;
  logic [RB-1:0]                 s1_ra, s1_rb;
  logic [RB:0]                   s1_rs;
  logic signed [MB-1:0]          dx, dy;

  assign dx = MB'(b_pos_x) - MB'(a_pos_x);
  assign dy = MB'(b_pos_y) - MB'(a_pos_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s1_mx    <= dx[MB-1] ? MB'(-dx) : MB'(dx);
      s1_my    <= dy[MB-1] ? MB'(-dy) : MB'(dy);
      s1_nxneg <= dx[MB-1];
      s1_nyneg <= dy[MB-1];
      s1_ra    <= a_radius;
      s1_rb    <= b_radius;
      s1_rs    <= {1'b0, a_radius} + {1'b0, b_radius};
    end
  end

  // stage 2: squares
  logic                          s2_valid;
  logic [ccc_pkg::SQ_BITS-1:0]   s2_sx, s2_sy;
  logic [2*(RB+1)-1:0]           s2_rs2;
  ccc_pkg::side_t                s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid      <= s1_valid;
      s2_sx         <= s1_mx * s1_mx;
      s2_sy         <= s1_my * s1_my;
      s2_rs2        <= s1_rs * s1_rs;
      s2_side.mx    <= s1_mx;
      s2_side.my    <= s1_my;
      s2_side.nxneg <= s1_nxneg;
      s2_side.nyneg <= s1_nyneg;
      s2_side.ra    <= s1_ra;
      s2_side.rb    <= s1_rb;
      s2_side.hit   <= 1'b0;
      s2_side.coinc <= 1'b0;
    end
  end

  // stage 3: squared distance against squared radius sum; feeds the root row
  logic [ccc_pkg::SQ_BITS-1:0]   d2;
  ccc_pkg::side_t                s3_side;
  ccc_pkg::sq_t                  sq [SQ_CELLS+1];

  assign d2 = s2_sx + s2_sy;

  // touching counts as a hit
  always_comb begin
    s3_side       = s2_side;
    s3_side.hit   = d2 <= ccc_pkg::SQ_BITS'(s2_rs2);
    s3_side.coinc = (s2_side.mx == '0) && (s2_side.my == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else begin
      sq[0].valid <= s2_valid;
      sq[0].rem   <= '0;
      sq[0].root  <= '0;
      sq[0].rad   <= d2;
      sq[0].side  <= s3_side;
    end
  end

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    ccc_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .d   (sq[i]),
      .q   (sq[i+1])
    );
  end

  // divider set-up: numerator is magnitude * 2^frac plus half the distance
  logic [ccc_pkg::ROOT_BITS-1:0] dist_root;
  logic [ccc_pkg::NUM_BITS-1:0]  num_x, num_y;
  ccc_pkg::dv_t                  dv [DIV_CELLS+1];

  assign dist_root = sq[SQ_CELLS].root;
  assign num_x = {sq[SQ_CELLS].side.mx, NF'(0)} + ccc_pkg::NUM_BITS'(dist_root >> 1);
  assign num_y = {sq[SQ_CELLS].side.my, NF'(0)} + ccc_pkg::NUM_BITS'(dist_root >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0].valid <= sq[SQ_CELLS].valid;
      dv[0].den   <= dist_root;
      dv[0].rem_x <= ccc_pkg::DREM_BITS'(num_x[ccc_pkg::NUM_BITS-1:DIV_CELLS]);
      dv[0].low_x <= num_x[DIV_CELLS-1:0];
      dv[0].q_x   <= '0;
      dv[0].rem_y <= ccc_pkg::DREM_BITS'(num_y[ccc_pkg::NUM_BITS-1:DIV_CELLS]);
      dv[0].low_y <= num_y[DIV_CELLS-1:0];
      dv[0].q_y   <= '0;
      dv[0].side  <= sq[SQ_CELLS].side;
    end
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    ccc_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .d   (dv[i]),
      .q   (dv[i+1])
    );
  end

  // pick the normal: forced along x when centres meet, zero on a miss
  ccc_pkg::dv_t                  dl;
  logic [ccc_pkg::QUOT_BITS-1:0] nxm, nym;
  logic                          nxneg, nyneg;

  assign dl = dv[DIV_CELLS];

  always_comb begin
    nxm   = dl.q_x;
    nym   = dl.q_y;
    nxneg = dl.side.nxneg;
    nyneg = dl.side.nyneg;
    if (!dl.side.hit) begin
      nxm   = '0;
      nym   = '0;
      nxneg = 1'b0;
      nyneg = 1'b0;
    end else if (dl.side.coinc) begin
      nxm   = ccc_pkg::QUOT_BITS'(1) << NF;
      nym   = '0;
      nxneg = 1'b0;
      nyneg = 1'b0;
    end
  end

  // multiply stage: normal times each radius
  logic                          m_valid, m_hit, m_coinc, m_nxneg, m_nyneg;
  logic [ccc_pkg::QUOT_BITS-1:0] m_nxm, m_nym;
  logic [ccc_pkg::PROD_BITS-1:0] p_ax, p_ay, p_bx, p_by;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= dl.valid;
      m_hit   <= dl.side.hit;
      m_coinc <= dl.side.hit && dl.side.coinc;
      m_nxneg <= nxneg;
      m_nyneg <= nyneg;
      m_nxm   <= nxm;
      m_nym   <= nym;
      p_ax    <= nxm * dl.side.ra;
      p_ay    <= nym * dl.side.ra;
      p_bx    <= nxm * dl.side.rb;
      p_by    <= nym * dl.side.rb;
    end
  end

  // round half up, then apply the signs; arm b points back against the normal
  localparam logic [ccc_pkg::PROD_BITS-1:0] HALF = ccc_pkg::PROD_BITS'(1) << (NF - 1);

  logic [ccc_pkg::COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
  logic [ccc_pkg::NORMAL_BITS-1:0] n_x, n_y;

  assign r_ax = ccc_pkg::COORD_BITS'((p_ax + HALF) >> NF);
  assign r_ay = ccc_pkg::COORD_BITS'((p_ay + HALF) >> NF);
  assign r_bx = ccc_pkg::COORD_BITS'((p_bx + HALF) >> NF);
  assign r_by = ccc_pkg::COORD_BITS'((p_by + HALF) >> NF);
  assign n_x  = ccc_pkg::NORMAL_BITS'(m_nxm);
  assign n_y  = ccc_pkg::NORMAL_BITS'(m_nym);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done       <= m_valid;
      hit        <= m_hit;
      coincident <= m_coinc;
      normal_x   <= m_nxneg ? -n_x : n_x;
      normal_y   <= m_nyneg ? -n_y : n_y;
      arm_a_x    <= m_nxneg ? -r_ax : r_ax;
      arm_a_y    <= m_nyneg ? -r_ay : r_ay;
      arm_b_x    <= m_nxneg ? r_bx : -r_bx;
      arm_b_y    <= m_nyneg ? r_by : -r_by;
    end
  end

endmodule

>>> dv/circle_circle_contact_tb.sv
`timescale 1ns / 1ps

module circle_circle_contact_tb;
  import ccc_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0]  ax, ay, bx, by;
    logic        [RADIUS_BITS-1:0] ra, rb;
  } pair_t;

  typedef struct {
    logic                          hit;
    logic signed [NORMAL_BITS-1:0] nx, ny;
    logic signed [COORD_BITS-1:0]  aax, aay, abx, aby;
    logic                          coinc;
  } contact_t;

  logic clk, rst, start, busy, done;
  logic signed [COORD_BITS-1:0]  a_pos_x, a_pos_y, b_pos_x, b_pos_y;
  logic        [RADIUS_BITS-1:0] a_radius, b_radius;
  logic                          hit, coincident;
  logic signed [NORMAL_BITS-1:0] normal_x, normal_y;
  logic signed [COORD_BITS-1:0]  arm_a_x, arm_a_y, arm_b_x, arm_b_y;

  pair_t    pair_q[$];
  contact_t contact_q[$];
  bit       failed, stim_done, taken;
  int       burst_left, gap_left;
  longint   cycles;

  circle_circle_contact dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint dx, dy;
    longint unsigned mx, my, d2, rs, root_d, nxm, nym, ax_m, ay_m, bx_m, by_m;
    bit xneg, yneg;
    c = '{default: '0};
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    xneg = dx < 0;
    yneg = dy < 0;
    mx = xneg ? -dx : dx;
    my = yneg ? -dy : dy;
    d2 = mx * mx + my * my;
    rs = longint'(p.ra) + longint'(p.rb);
    // Distance beyond the radius sum: no contact, all other fields zero.
    if (d2 > rs * rs) return c;
    if (mx == 0 && my == 0) begin
      // Centres coincide: force the normal along +x.
      c.coinc = 1'b1;
      nxm  = 64'd1 << NORMAL_FRAC_BITS;
      nym  = 0;
      xneg = 0;
      yneg = 0;
    end else begin
      root_d = int_sqrt(d2);
      nxm    = ((mx << NORMAL_FRAC_BITS) + (root_d >> 1)) / root_d;
      nym    = ((my << NORMAL_FRAC_BITS) + (root_d >> 1)) / root_d;
    end
    ax_m = (nxm * p.ra + (64'd1 << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS;
    ay_m = (nym * p.ra + (64'd1 << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS;
    bx_m = (nxm * p.rb + (64'd1 << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS;
    by_m = (nym * p.rb + (64'd1 << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS;
    c.hit = 1'b1;
    c.nx  = xneg ? -nxm : nxm;
    c.ny  = yneg ? -nym : nym;
    c.aax = xneg ? -ax_m : ax_m;
    c.aay = yneg ? -ay_m : ay_m;
    c.abx = xneg ? bx_m : -bx_m;
    c.aby = yneg ? by_m : -by_m;
    return c;
  endfunction

  function automatic pair_t mk_pair(longint ax, longint ay, longint ra,
                                    longint bx, longint by, longint rb);
    pair_t p;
    p.ax = ax; p.ay = ay; p.ra = ra;
    p.bx = bx; p.by = by; p.rb = rb;
    return p;
  endfunction

  // Random pair, mostly placed near the contact boundary.
  function automatic pair_t rand_pair();
    pair_t  p;
    longint rs, span, bx, by;
    int     sel;
    p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
    p.ra = $urandom; p.rb = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 2) return p;
    case ($urandom_range(0, 3))
      0: begin p.ra = $urandom_range(0, 15);    p.rb = $urandom_range(0, 15);    end
      1: begin p.ra = $urandom_range(0, 4095);  p.rb = $urandom_range(0, 4095);  end
      2: begin p.ra = $urandom_range(0, 1 << 18); p.rb = $urandom_range(0, 1 << 18); end
      default: ;
    endcase
    rs   = longint'(p.ra) + longint'(p.rb);
    span = rs + rs / 4 + 2;
    if (sel == 9) span = 2;
    bx = longint'(p.ax) + longint'($urandom_range(0, 2 * span)) - span;
    by = longint'(p.ay) + longint'($urandom_range(0, 2 * span)) - span;
    if (sel == 8 && span < 2000) begin
      bx = p.ax;
      by = p.ay;
    end
    if (bx < -(64'sd1 << 23) || bx >= (64'sd1 << 23) ||
        by < -(64'sd1 << 23) || by >= (64'sd1 << 23)) begin
      // Shift a so that b stays in range.
      bx = bx - longint'(p.ax);
      by = by - longint'(p.ay);
      p.ax = -bx / 2;
      p.ay = -by / 2;
      bx = bx + longint'(p.ax);
      by = by + longint'(p.ay);
    end
    p.bx = bx;
    p.by = by;
    return p;
  endfunction

  initial begin
    longint mx, mn, rm;
    mx = (64'sd1 << 23) - 1;
    mn = -(64'sd1 << 23);
    rm = (64'sd1 << 23) - 1;
    // Directed: zeros, coincident, touching, just apart, every quadrant, extremes.
    pair_q.push_back(mk_pair(0, 0, 0, 0, 0, 0));
    pair_q.push_back(mk_pair(mx, mn, rm, mx, mn, rm));
    pair_q.push_back(mk_pair(mn, mn, 0, mn, mn, 0));
    pair_q.push_back(mk_pair(0, 0, 2, 3, 4, 3));
    pair_q.push_back(mk_pair(0, 0, 2, 3, 4, 2));
    pair_q.push_back(mk_pair(10, 10, 2, 7, 6, 3));
    pair_q.push_back(mk_pair(-5, 7, 1, -2, 3, 4));
    pair_q.push_back(mk_pair(100, 0, 50, 0, 0, 50));
    pair_q.push_back(mk_pair(0, 100, 50, 0, 0, 50));
    pair_q.push_back(mk_pair(0, 0, 50, 0, 101, 50));
    pair_q.push_back(mk_pair(mn, mn, rm, mx, mx, rm));
    pair_q.push_back(mk_pair(mx, mx, rm, mn, mn, rm));
    pair_q.push_back(mk_pair(mn, 0, rm, mx, 0, rm));
    pair_q.push_back(mk_pair(0, mx, rm, 0, mn, rm));
    pair_q.push_back(mk_pair(mn, mn, 0, mx, mx, 0));
    pair_q.push_back(mk_pair(0, 0, rm, 1, 1, 0));
    pair_q.push_back(mk_pair(0, 0, 0, -1, 0, 1));
    pair_q.push_back(mk_pair(0, 0, rm, -7, 3, rm));
    pair_q.push_back(mk_pair(mx, mx, 1, mx - 1, mx - 1, 1));
    repeat (1550) pair_q.push_back(rand_pair());
    stim_done = 1'b1;
  end

  // Driver: bursts with random gaps, inputs change on the falling edge.
  always @(negedge clk) begin
    pair_t p;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        void'(pair_q.pop_front());
        taken = 1'b0;
      end
      if (gap_left > 0 || pair_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        p = pair_q[0];
        a_pos_x <= p.ax; a_pos_y <= p.ay; a_radius <= p.ra;
        b_pos_x <= p.bx; b_pos_y <= p.by; b_radius <= p.rb;
        start   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Monitor: check results first, then record the item taken at this edge.
  always @(posedge clk) begin
    contact_t e;
    pair_t    p;
    if (!rst) begin
      cycles++;
      if (done) begin
        if (contact_q.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          failed = 1'b1;
        end else begin
          e = contact_q.pop_front();
          if (hit !== e.hit || normal_x !== e.nx || normal_y !== e.ny ||
              arm_a_x !== e.aax || arm_a_y !== e.aay || arm_b_x !== e.abx ||
              arm_b_y !== e.aby || coincident !== e.coinc) begin
            $display("%0t: mismatch exp hit=%0d n=(%0d,%0d) a=(%0d,%0d) b=(%0d,%0d) c=%0d",
                     $time, e.hit, e.nx, e.ny, e.aax, e.aay, e.abx, e.aby, e.coinc);
            $display("%0t:          got hit=%0d n=(%0d,%0d) a=(%0d,%0d) b=(%0d,%0d) c=%0d",
                     $time, hit, normal_x, normal_y, arm_a_x, arm_a_y, arm_b_x,
                     arm_b_y, coincident);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        p.ax = a_pos_x; p.ay = a_pos_y; p.ra = a_radius;
        p.bx = b_pos_x; p.by = b_pos_y; p.rb = b_radius;
        contact_q.push_back(predict_contact(p));
        taken = 1'b1;
      end
      if (cycles > 200000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    a_pos_x = '0; a_pos_y = '0; a_radius = '0;
    b_pos_x = '0; b_pos_y = '0; b_radius = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Drain: all items taken, all results back, then allow the pipeline to settle.
    wait (stim_done && pair_q.size() == 0 && contact_q.size() == 0);
    repeat (60) @(posedge clk);
    if (!failed && contact_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ccc_pkg.sv
rtl/ccc_sqrt_cell.sv
rtl/ccc_div_cell.sv
rtl/circle_circle_contact.sv
dv/circle_circle_contact_tb.sv
